// ----- rtl/varint_field_tuple_validator_unit_defines.svh -----
// Assertion macros shared by the validator modules.
`ifndef VARINT_FIELD_TUPLE_VALIDATOR_UNIT_DEFINES_SVH
`define VARINT_FIELD_TUPLE_VALIDATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFTV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vftv_pkg.sv -----
`default_nettype none

package vftv_pkg;

  localparam logic [2:0] MAX_VARINT_BYTES = 3'd5;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2,
    PH_BAD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] tuple_length;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/vftv_core.sv -----
`default_nettype none

`include "varint_field_tuple_validator_unit_defines.svh"

module vftv_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output logic                 res_valid,
  output vftv_pkg::result_t    res
);
  import vftv_pkg::*;

  logic [15:0] field_count;
  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] varint_value;
  logic [31:0] varint_value_next;
  logic [2:0]  varint_bytes;
  logic [2:0]  varint_bytes_next;
  logic [31:0] bytes_to_skip;
  logic [31:0] bytes_to_skip_next;
  logic [15:0] fields_done;
  logic [15:0] fields_done_next;
  logic [31:0] consumed_bytes;
  logic [31:0] consumed_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count    <= 16'd0;
      phase          <= PH_LEN;
      varint_value   <= 32'd0;
      varint_bytes   <= 3'd0;
      bytes_to_skip  <= 32'd0;
      fields_done    <= 16'd0;
      consumed_bytes <= 32'd0;
    end else begin
      if (cfg_write) begin
        field_count <= cfg_data;
      end
      phase          <= phase_next;
      varint_value   <= varint_value_next;
      varint_bytes   <= varint_bytes_next;
      bytes_to_skip  <= bytes_to_skip_next;
      fields_done    <= fields_done_next;
      consumed_bytes <= consumed_bytes_next;
    end
  end

  always_comb begin
    phase_t      ph;
    logic [31:0] acc;
    logic [2:0]  cnt;
    logic [15:0] done_inc;
    logic [31:0] skip_dec;

    ph       = phase;
    acc      = {varint_value[24:0], data_byte[6:0]};
    cnt      = varint_bytes + 3'd1;
    done_inc = fields_done + 16'd1;
    skip_dec = bytes_to_skip - 32'd1;

    phase_next          = phase;
    varint_value_next   = varint_value;
    varint_bytes_next   = varint_bytes;
    bytes_to_skip_next  = bytes_to_skip;
    fields_done_next    = fields_done;
    consumed_bytes_next = consumed_bytes;
    res_valid           = 1'b0;
    res.status          = STATUS_SHORT;
    res.tuple_length    = 32'd0;

    if (step) begin
      if (ph == PH_LEN && fields_done >= field_count) begin
        ph = PH_DONE;
      end
      phase_next = ph;

      unique case (ph)
        PH_LEN: begin
          consumed_bytes_next = consumed_bytes + 32'd1;
          if (data_byte[7]) begin
            varint_value_next = acc;
            varint_bytes_next = cnt;
            if (cnt >= MAX_VARINT_BYTES) begin
              phase_next = PH_BAD;
            end
          end else begin
            bytes_to_skip_next = acc;
            varint_value_next  = 32'd0;
            varint_bytes_next  = 3'd0;
            if (acc == 32'd0) begin
              fields_done_next = done_inc;
              phase_next = (done_inc >= field_count) ? PH_DONE : PH_LEN;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          consumed_bytes_next = consumed_bytes + 32'd1;
          bytes_to_skip_next  = skip_dec;
          if (skip_dec == 32'd0) begin
            fields_done_next = done_inc;
            phase_next = (done_inc >= field_count) ? PH_DONE : PH_LEN;
          end
        end
        PH_DONE, PH_BAD: begin
        end
        default: begin
        end
      endcase

      if (last_byte) begin
        res_valid = 1'b1;
        if (phase_next == PH_LEN && fields_done_next >= field_count) begin
          phase_next = PH_DONE;
        end
        unique case (phase_next)
          PH_DONE: begin
            res.status       = STATUS_OK;
            res.tuple_length = consumed_bytes_next;
          end
          PH_BAD: res.status = STATUS_LONG;
          default: res.status = STATUS_SHORT;
        endcase
        phase_next          = PH_LEN;
        varint_value_next   = 32'd0;
        varint_bytes_next   = 3'd0;
        bytes_to_skip_next  = 32'd0;
        fields_done_next    = 16'd0;
        consumed_bytes_next = 32'd0;
      end
    end
  end

  `VFTV_ASSERT_IMPL(a_data_has_bytes, clk, rst, phase == PH_DATA, bytes_to_skip != 32'd0,
                    "Data phase entered with no bytes left to skip.")
  `VFTV_ASSERT_IMPL(a_varint_short, clk, rst, phase == PH_LEN,
                    varint_bytes < MAX_VARINT_BYTES, "Varint byte count ran past its limit.")
  `VFTV_ASSERT_IMPL(a_fail_no_length, clk, rst, res_valid && res.status != STATUS_OK,
                    res.tuple_length == 32'd0, "Failed result carries a nonzero length.")

endmodule

`default_nettype wire

// ----- rtl/vftv_out_buf.sv -----
`default_nettype none

`include "varint_field_tuple_validator_unit_defines.svh"

module vftv_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vftv_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output vftv_pkg::result_t      out_data
);
  import vftv_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  `VFTV_ASSERT_IMPL(a_skid_behind_main, clk, rst, skid_valid, main_valid,
                    "Skid word held with the output register empty.")
  `VFTV_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !skid_valid,
                    "Result word pushed while the skid stage is full.")
  `VFTV_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall,
                    main_valid && !skid_valid, "Skid word not moved up after a drain.")

endmodule

`default_nettype wire

// ----- rtl/varint_field_tuple_validator_unit.sv -----
// A result word is presented the cycle after its last input byte is taken, unless
// an older word still waits in the output buffer. Throughput: one input byte per
// cycle while in_stall is low; all field, varint and length state is updated per
// byte, and a two-word output buffer absorbs stalls. Reset: synchronous, active
// high; clears field_count to zero, the parse state and the output buffer.
`default_nettype none

module varint_field_tuple_validator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      tuple_length
);
  import vftv_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    full;

  assign cfg_ready    = 1'b1;
  assign in_stall     = full;
  assign step         = in_valid && !full;
  assign status       = out_data.status;
  assign tuple_length = out_data.tuple_length;

  vftv_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  vftv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/varint_field_tuple_validator_checker.sv -----
`timescale 1ns / 100ps

module varint_field_tuple_validator_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  status,
  input  wire logic [31:0] tuple_length,
  output int               mismatches,
  output int               pending,
  output int               results_checked
);

  import vftv_pkg::*;

  logic [15:0] field_count;
  phase_t      parse_phase;
  logic [31:0] length_acc;
  logic [2:0]  groups_seen;
  logic [31:0] data_left;
  logic [15:0] fields_seen;
  logic [31:0] tuple_bytes;
  result_t     expected_tuples[$];
  result_t     oldest;

  task automatic clear_parse();
    parse_phase = PH_LEN;
    length_acc  = '0;
    groups_seen = '0;
    data_left   = '0;
    fields_seen = '0;
    tuple_bytes = '0;
  endtask

  task automatic close_field();
    fields_seen = fields_seen + 16'd1;
    parse_phase = (fields_seen >= field_count) ? PH_DONE : PH_LEN;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (parse_phase == PH_LEN && fields_seen >= field_count) parse_phase = PH_DONE;
    if (parse_phase == PH_LEN) begin
      tuple_bytes = tuple_bytes + 32'd1;
      length_acc  = {length_acc[24:0], b[6:0]};
      groups_seen = groups_seen + 3'd1;
      if (b[7]) begin
        if (groups_seen >= MAX_VARINT_BYTES) parse_phase = PH_BAD;
      end else begin
        data_left   = length_acc;
        length_acc  = '0;
        groups_seen = '0;
        if (data_left == 32'd0) close_field();
        else parse_phase = PH_DATA;
      end
    end else if (parse_phase == PH_DATA) begin
      tuple_bytes = tuple_bytes + 32'd1;
      data_left   = data_left - 32'd1;
      if (data_left == 32'd0) close_field();
    end
    if (last) begin
      if (parse_phase == PH_LEN && fields_seen >= field_count) parse_phase = PH_DONE;
      case (parse_phase)
        PH_DONE: begin
          r.status       = STATUS_OK;
          r.tuple_length = tuple_bytes;
        end
        PH_BAD: begin
          r.status       = STATUS_LONG;
          r.tuple_length = '0;
        end
        default: begin
          r.status       = STATUS_SHORT;
          r.tuple_length = '0;
        end
      endcase
      expected_tuples.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      field_count = '0;
      clear_parse();
      expected_tuples.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tuples.size() == 0) begin
          if (mismatches < 10)
            $display("mismatch: result word status %0d length %0d with nothing expected",
                     status, tuple_length);
          mismatches = mismatches + 1;
        end else begin
          oldest = expected_tuples.pop_front();
          results_checked = results_checked + 1;
          if (status != oldest.status || tuple_length != oldest.tuple_length) begin
            if (mismatches < 10)
              $display("mismatch: expected status %0d length %0d, got status %0d length %0d",
                       oldest.status, oldest.tuple_length, status, tuple_length);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(data_byte, last_byte);
      if (cfg_valid && cfg_ready) field_count = cfg_data;
    end
    pending = expected_tuples.size();
  end

endmodule

// ----- bench/tb_varint_field_tuple_validator_unit.sv -----
`timescale 1ns / 100ps

module tb_varint_field_tuple_validator_unit;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 206;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] tuple_length;

  int mismatches;
  int pending;
  int results_checked;

  int   cycles;
  int   bytes_sent;
  int   frames_sent;
  int   settings_used;
  int   holds_asked;
  bit   calm;
  logic [7:0] frame_bytes[$];

  varint_field_tuple_validator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tuple_length (tuple_length)
  );

  varint_field_tuple_validator_checker watch (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .tuple_length    (tuple_length),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycles = cycles + 1;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_field_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 3);
    if (r < 85) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  function automatic int min_groups(input logic [31:0] len);
    int n;
    n = 1;
    while (n < 5 && (len >> (7 * n)) != 0) n = n + 1;
    return n;
  endfunction

  task automatic push_random_byte();
    frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Padded prefixes use extra leading groups; a fifth group carries junk in its dropped bits.
  task automatic push_length(input logic [31:0] len, input bit padded);
    int groups;
    logic [7:0] g;
    groups = min_groups(len);
    if (padded) groups = $urandom_range(groups, 5);
    for (int i = groups - 1; i >= 0; i--) begin
      g = 8'((len >> (7 * i)) & 32'h7f);
      if (i == 4) g[6:4] = 3'($urandom_range(0, 7));
      g[7] = (i > 0);
      frame_bytes.push_back(g);
    end
  endtask

  task automatic push_field(input int len);
    push_length(32'(len), $urandom_range(0, 3) == 0);
    repeat (len) push_random_byte();
  endtask

  task automatic build_frame(input int fields);
    int kind;
    int n;
    int cut;
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    n = (fields > 6) ? 6 : fields;
    if (kind < 60) begin
      repeat (n) push_field(pick_field_length());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_random_byte();
    end else if (kind < 75) begin
      repeat (n) push_field(pick_field_length());
      if ($urandom_range(0, 1) == 1) push_length($urandom(), 1'b1);
      if (frame_bytes.size() > 1) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
    end else if (kind < 85) begin
      if (n > 0) repeat ($urandom_range(0, n - 1)) push_field(pick_field_length());
      repeat (5) frame_bytes.push_back(8'($urandom_range(128, 255)));
      repeat ($urandom_range(0, 3)) push_random_byte();
    end else begin
      repeat ($urandom_range(1, 8)) push_random_byte();
    end
    if (frame_bytes.size() == 0) push_random_byte();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent = frames_sent + 1;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_field_count(input logic [15:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used = settings_used + 1;
  endtask

  initial begin : receiver
    int run;
    int gap;
    int holds_done;
    out_stall = 1'b0;
    holds_done = 0;
    forever begin
      if (holds_done < holds_asked) begin
        holds_done = holds_done + 1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        run = calm ? 60 : $urandom_range(1, 12);
        @(negedge clk);
        out_stall <= 1'b0;
        repeat (run - 1) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] counts[8];
    int start;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    bytes_sent = 0;
    frames_sent = 0;
    settings_used = 0;
    holds_asked = 0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no fields the tuple is complete before the first byte.
    write_field_count(16'd0);
    frame_bytes = '{8'h42};
    send_frame();

    // A zero-length field, a two-byte field and a trailing byte that is ignored.
    write_field_count(16'd2);
    frame_bytes = '{8'h00, 8'h02, 8'hAA, 8'h55, 8'hFF};
    send_frame();

    write_field_count(16'd1);
    frame_bytes = '{8'hF0, 8'h80, 8'h80, 8'h80, 8'h01, 8'h7F};
    send_frame();
    frame_bytes = '{8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h00};
    send_frame();
    frame_bytes = '{8'h03, 8'h11};
    send_frame();
    frame_bytes = '{8'h81};
    send_frame();
    frame_bytes = '{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_frame();

    write_field_count(16'hFFFF);
    frame_bytes = '{8'h00, 8'h00};
    send_frame();

    counts = '{16'd1, 16'd3, 16'd0, 16'd2, 16'hFFFF, 16'd5, 16'd7, 16'd1};
    counts[5] = 16'($urandom_range(4, 6));
    counts[6] = 16'($urandom_range(7, 65535));
    for (int p = 0; p < 8; p++) begin
      write_field_count(counts[p]);
      calm = ($urandom_range(0, 3) == 0);
      if (p == 1 || p == 5) holds_asked = holds_asked + 1;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        build_frame(int'(counts[p]));
        send_frame();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d result words from %0d buffers (%0d bytes) over %0d settings.",
             results_checked, frames_sent, bytes_sent, settings_used);
    $display("Buffers mixed well-formed tuples, padded and overlong varints, truncation and noise.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
